// ===== sv/tssp_pkg.sv =====
// Shared types, constants and helpers of the stepping-stone pivot block.
// Used by tssp_ctrl, tssp_dp and transport_stepping_stone_pivot; no dependencies.
`default_nettype none

package tssp_pkg;

   localparam int N_SUP   = 8;
   localparam int N_CLI   = 8;
   localparam int N_ARCS  = 16;
   localparam int N_NODES = 16;
   localparam int AMT_W   = 31;
   localparam logic [AMT_W-1:0] AMT_MAX = '1;

   // Item kinds.
   localparam logic [2:0] KIND_CLEAR = 3'd0;
   localparam logic [2:0] KIND_ADD   = 3'd1;
   localparam logic [2:0] KIND_WRITE = 3'd2;
   localparam logic [2:0] KIND_READ  = 3'd3;
   localparam logic [2:0] KIND_PIVOT = 3'd4;

   // Result status codes.
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOPATH = 2'd1;
   localparam logic [1:0] STAT_NOLEAV = 2'd2;
   localparam logic [1:0] STAT_RANGE  = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_NSUP = 1'b0;
   localparam logic CSR_NCLI = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD_TAKE, S_POP, S_SCAN, S_WALK,
      S_TH_RD, S_TH_TAKE, S_UP_RD, S_UP_WR, S_LV_RD, S_LV_TAKE, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_CLEAR, CMD_ADD, CMD_WRITE, CMD_ERR,
      CMD_RD_ISSUE, CMD_RD_TAKE, CMD_SRCH_INIT, CMD_POP, CMD_SCAN,
      CMD_NOPATH, CMD_WALK_INIT, CMD_WALK, CMD_TH_INIT, CMD_TH_TAKE,
      CMD_UP_WRITE, CMD_LV_TAKE, CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       bad;
      logic       full;
      logic       too_big;
      logic       q_go;
      logic       dst_seen;
      logic       k_go;
      logic       at_root;
      logic       step1_more;
      logic       step2_more;
      logic       rd_zero;
      logic       rsp_free;
   } flags_type;

   function automatic logic [3:0] clamp_cfg(input logic [3:0] v, input logic [3:0] hi);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) begin
         r = 4'd1;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tssp_ctrl.sv =====
// Controller state machine of the stepping-stone pivot block.
// Depends on tssp_pkg; drives tssp_dp through one command per cycle.
`default_nettype none

module tssp_ctrl
   import tssp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_tvalid,
   output logic           req_tready,
   input  wire flags_type flags,
   output cmd_type        cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_DONE;
            if (flags.kind == KIND_READ && !flags.bad) begin
               state_in = S_RD_TAKE;
            end else if (flags.kind == KIND_PIVOT && !flags.bad && !flags.too_big) begin
               state_in = S_POP;
            end
         end
         S_RD_TAKE: state_in = S_DONE;
         S_POP: begin
            priority if (flags.q_go) begin
               state_in = S_SCAN;
            end else if (flags.dst_seen) begin
               state_in = S_WALK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (!flags.k_go) state_in = S_POP;
         end
         S_WALK: begin
            if (flags.at_root) state_in = S_TH_RD;
         end
         S_TH_RD: state_in = S_TH_TAKE;
         S_TH_TAKE: state_in = flags.step2_more ? S_TH_RD : S_UP_RD;
         S_UP_RD: state_in = S_UP_WR;
         S_UP_WR: state_in = flags.step1_more ? S_UP_RD : S_LV_RD;
         S_LV_RD: state_in = S_LV_TAKE;
         S_LV_TAKE: begin
            if (flags.rd_zero || !flags.step2_more) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LV_RD;
            end
         end
         S_DONE: begin
            if (flags.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = CMD_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // No transaction is taken while reset is held.
            req_tready = !reset;
            if (req_tvalid && !reset) cmd = CMD_LOAD;
         end
         S_DECODE: begin
            unique case (flags.kind)
               KIND_CLEAR: cmd = CMD_CLEAR;
               KIND_ADD:   cmd = (flags.bad || flags.full) ? CMD_ERR : CMD_ADD;
               KIND_WRITE: cmd = flags.bad ? CMD_ERR : CMD_WRITE;
               KIND_READ:  cmd = flags.bad ? CMD_ERR : CMD_RD_ISSUE;
               KIND_PIVOT: cmd = (flags.bad || flags.too_big) ? CMD_ERR : CMD_SRCH_INIT;
               default:    cmd = CMD_NONE;
            endcase
         end
         S_RD_TAKE: cmd = CMD_RD_TAKE;
         S_POP: begin
            priority if (flags.q_go) begin
               cmd = CMD_POP;
            end else if (flags.dst_seen) begin
               cmd = CMD_WALK_INIT;
            end else begin
               cmd = CMD_NOPATH;
            end
         end
         S_SCAN: cmd = flags.k_go ? CMD_SCAN : CMD_NONE;
         S_WALK: cmd = flags.at_root ? CMD_TH_INIT : CMD_WALK;
         S_TH_TAKE: cmd = CMD_TH_TAKE;
         S_UP_WR: cmd = CMD_UP_WRITE;
         S_LV_TAKE: cmd = CMD_LV_TAKE;
         S_DONE: cmd = flags.rsp_free ? CMD_EMIT : CMD_NONE;
         default: cmd = CMD_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/tssp_dp.sv =====
// Datapath of the stepping-stone pivot block: basis, cell memory, search scratch,
// cycle list and result registers. Depends on tssp_pkg; commanded by tssp_ctrl.
`default_nettype none

module tssp_dp
   import tssp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output flags_type        flags,
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [3:0]  csr_wdata
);

   logic [3:0] nsup_ff, ncli_ff;
   logic [2:0] kind_ff, row_ff, col_ff;
   logic [AMT_W-1:0] value_ff;

   logic [2:0] arc_r_ff [N_ARCS];
   logic [2:0] arc_c_ff [N_ARCS];
   logic [4:0] arc_cnt_ff;

   logic [AMT_W-1:0] mem [64];
   logic [63:0]      vld_ff;
   logic [AMT_W-1:0] mem_rd_ff;
   logic             vld_rd_ff;

   logic [3:0]  parent_ff [N_NODES];
   logic [3:0]  queue_ff  [N_NODES];
   logic [15:0] seen_ff;
   logic [4:0]  head_ff, tail_ff, k_ff;
   logic [3:0]  u_ff, cur_ff;
   logic [5:0]  path_ff [16];
   logic [4:0]  plen_ff, e_ff;
   logic [AMT_W-1:0] theta_ff;

   logic [1:0]       res_status_ff;
   logic [2:0]       res_lrow_ff, res_lcol_ff;
   logic [AMT_W-1:0] res_rdval_ff;

   logic             rsp_valid_ff;
   logic [71:0]      rsp_data_ff;

   logic [4:0] dst5, nplusm, cc5;
   logic [3:0] dst, arc_a, arc_cn, nb, up;
   logic [4:0] pidx;
   logic [5:0] cell_e, cell_walk, rd_addr, wr_addr;
   logic [AMT_W-1:0] rd_val, wr_val, up_val;
   logic       wr_en, arc_ok, nb_hit, row_ok, col_ok;
   logic [2:0] cur_col, up_col;

   assign dst5   = {1'b0, nsup_ff} + {2'b00, col_ff};
   assign dst    = dst5[3:0];
   assign nplusm = {1'b0, nsup_ff} + {1'b0, ncli_ff};
   assign row_ok = {1'b0, row_ff} < nsup_ff;
   assign col_ok = {1'b0, col_ff} < ncli_ff;
   assign rd_val = vld_rd_ff ? mem_rd_ff : '0;

   // Cycle cell e: the entering cell first, then the walked path in reverse.
   assign pidx   = plen_ff - e_ff;
   assign cell_e = (e_ff == 5'd0) ? {row_ff, col_ff} : path_ff[pidx[3:0]];

   // Neighbor of the popped node over arc k, if the arc is live and touches it.
   assign arc_a  = {1'b0, arc_r_ff[k_ff[3:0]]};
   assign cc5    = {1'b0, nsup_ff} + {2'b00, arc_c_ff[k_ff[3:0]]};
   assign arc_cn = cc5[3:0];
   assign arc_ok = (arc_a < nsup_ff) && ({1'b0, arc_c_ff[k_ff[3:0]]} < ncli_ff);
   always_comb begin
      nb     = arc_cn;
      nb_hit = 1'b0;
      if (arc_ok) begin
         if (u_ff == arc_a) begin
            nb     = arc_cn;
            nb_hit = 1'b1;
         end else if (u_ff == arc_cn) begin
            nb     = arc_a;
            nb_hit = 1'b1;
         end
      end
   end

   // Path edge between cur and its parent.
   assign up      = parent_ff[cur_ff];
   assign cur_col = 3'(cur_ff - nsup_ff);
   assign up_col  = 3'(up - nsup_ff);
   assign cell_walk = (cur_ff < nsup_ff) ? {cur_ff[2:0], up_col} : {up[2:0], cur_col};

   always_comb begin
      if (e_ff[0]) begin
         up_val = (rd_val < theta_ff) ? '0 : rd_val - theta_ff;
      end else begin
         up_val = (rd_val > AMT_MAX - theta_ff) ? AMT_MAX : rd_val + theta_ff;
      end
   end

   assign rd_addr = (cmd == CMD_RD_ISSUE) ? {row_ff, col_ff} : cell_e;
   assign wr_en   = (cmd == CMD_WRITE) || (cmd == CMD_UP_WRITE);
   assign wr_addr = (cmd == CMD_WRITE) ? {row_ff, col_ff} : cell_e;
   assign wr_val  = (cmd == CMD_WRITE) ? value_ff : up_val;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_val;
      mem_rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nsup_ff <= 4'd1;
         ncli_ff <= 4'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NSUP: nsup_ff <= clamp_cfg(csr_wdata, 4'(N_SUP));
            CSR_NCLI: ncli_ff <= clamp_cfg(csr_wdata, 4'(N_CLI));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd == CMD_CLEAR) arc_cnt_ff <= '0;
         if (cmd == CMD_ADD) arc_cnt_ff <= arc_cnt_ff + 5'd1;
         if (cmd == CMD_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_LOAD: begin
            kind_ff       <= req_tdata[2:0];
            row_ff        <= req_tdata[5:3];
            col_ff        <= req_tdata[8:6];
            value_ff      <= req_tdata[39:9];
            res_status_ff <= STAT_OK;
            res_lrow_ff   <= '0;
            res_lcol_ff   <= '0;
            res_rdval_ff  <= '0;
            theta_ff      <= '0;
         end
         CMD_ADD: begin
            arc_r_ff[arc_cnt_ff[3:0]] <= row_ff;
            arc_c_ff[arc_cnt_ff[3:0]] <= col_ff;
         end
         CMD_ERR: res_status_ff <= STAT_RANGE;
         CMD_RD_TAKE: res_rdval_ff <= rd_val;
         CMD_SRCH_INIT: begin
            queue_ff[0]                <= {1'b0, row_ff};
            parent_ff[{1'b0, row_ff}]  <= {1'b0, row_ff};
            seen_ff                    <= 16'(1) << row_ff;
            head_ff                    <= 5'd0;
            tail_ff                    <= 5'd1;
         end
         CMD_POP: begin
            u_ff    <= queue_ff[head_ff[3:0]];
            head_ff <= head_ff + 5'd1;
            k_ff    <= 5'd0;
         end
         CMD_SCAN: begin
            k_ff <= k_ff + 5'd1;
            if (nb_hit && !seen_ff[nb] && tail_ff < 5'(N_NODES)) begin
               seen_ff[nb]              <= 1'b1;
               parent_ff[nb]            <= u_ff;
               queue_ff[tail_ff[3:0]]   <= nb;
               tail_ff                  <= tail_ff + 5'd1;
            end
         end
         CMD_NOPATH: res_status_ff <= STAT_NOPATH;
         CMD_WALK_INIT: begin
            cur_ff  <= dst;
            plen_ff <= 5'd0;
         end
         CMD_WALK: begin
            path_ff[plen_ff[3:0]] <= cell_walk;
            plen_ff               <= plen_ff + 5'd1;
            cur_ff                <= up;
         end
         CMD_TH_INIT: e_ff <= 5'd1;
         CMD_TH_TAKE: begin
            if (e_ff == 5'd1 || rd_val < theta_ff) theta_ff <= rd_val;
            e_ff <= flags.step2_more ? e_ff + 5'd2 : 5'd0;
         end
         CMD_UP_WRITE: e_ff <= flags.step1_more ? e_ff + 5'd1 : 5'd1;
         CMD_LV_TAKE: begin
            if (rd_val == '0) begin
               res_status_ff <= STAT_OK;
               res_lrow_ff   <= cell_e[5:3];
               res_lcol_ff   <= cell_e[2:0];
            end else if (!flags.step2_more) begin
               res_status_ff <= STAT_NOLEAV;
            end
            e_ff <= e_ff + 5'd2;
         end
         CMD_EMIT: begin
            rsp_data_ff <= {2'b00, res_rdval_ff, res_lcol_ff, res_lrow_ff,
                            theta_ff, res_status_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      flags.kind       = kind_ff;
      flags.bad        = !(row_ok && col_ok);
      flags.full       = arc_cnt_ff >= 5'(N_ARCS);
      flags.too_big    = nplusm > 5'(N_NODES);
      flags.q_go       = (head_ff < tail_ff) && !seen_ff[dst];
      flags.dst_seen   = seen_ff[dst];
      flags.k_go       = k_ff < arc_cnt_ff;
      flags.at_root    = cur_ff == {1'b0, row_ff};
      flags.step1_more = e_ff < plen_ff;
      flags.step2_more = ({1'b0, e_ff} + 6'd2) <= {1'b0, plen_ff};
      flags.rd_zero    = rd_val == '0;
      flags.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_arc_cnt: assert property (@(posedge clock) disable iff (reset)
      arc_cnt_ff <= 5'(N_ARCS)) else $error("arc count beyond basis size");
   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_POP |-> head_ff < tail_ff) else $error("queue popped while empty");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_EMIT |=> rsp_valid_ff) else $error("result not presented");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_EMIT |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");

endmodule

`default_nettype wire

// ===== sv/transport_stepping_stone_pivot.sv =====
// Top level of the stepping-stone pivot block of the transportation method.
// Depends on tssp_pkg, tssp_ctrl and tssp_dp.
//
// Items enter on the req_ stream and each gives exactly one result transaction
// on the rsp_ stream. Items clear or append basis arcs, write or read one of
// 64 allocation cells, or pivot on an entering cell. The csr_ port sets the
// rows and columns in use; write it only while the block is idle.
// One item is worked on at a time. A pivot runs a breadth-first search that
// visits each reached node once and scans every basis arc for it, then walks
// the path back one edge at a time, and makes theta, update and leaving-cell
// passes over the cell memory, which has one read port and one write port.
// Reset empties the basis, makes every cell read as zero and sets both sizes to one.
// A finished result waits in an output register; while the receiver stalls
// the block holds it and takes no further item once the next result is done.
`default_nettype none

module transport_stepping_stone_pivot
   import tssp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // kind[2:0], row[5:3], col[8:6], value[39:9]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // status[1:0], theta[32:2], leave_row[35:33],
                                        // leave_col[38:36], read_value[69:39], zeros
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [3:0]  csr_wdata
);

   cmd_type   cmd;
   flags_type flags;

   tssp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   tssp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== dv/tb_transport_stepping_stone_pivot.sv =====
// Self-checking testbench of the stepping-stone pivot block: a driver, a receiver,
// a monitor with its own model of the basis, the cells and the pivot search.
// Depends on tssp_pkg and transport_stepping_stone_pivot.
`default_nettype none

module tb_transport_stepping_stone_pivot;
   import tssp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] KIND_UNUSED_MIN = 3'd5;
   localparam logic [2:0] KIND_UNUSED_MAX = 3'd7;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;
   localparam int ITEM_TARGET = 1350;

   typedef struct packed {
      logic [30:0] value;
      logic [2:0]  col;
      logic [2:0]  row;
      logic [2:0]  kind;
   } item_t;

   typedef struct packed {
      logic [30:0] read_value;
      logic [2:0]  leave_col;
      logic [2:0]  leave_row;
      logic [30:0] theta;
      logic [1:0]  status;
   } outcome_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [3:0]  csr_wdata = '0;

   // Size settings for the directed phases.
   logic [3:0] sup_cfg [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd8, 4'd5};
   logic [3:0] cli_cfg [8] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd5, 4'd8, 4'd1, 4'd4};

   transport_stepping_stone_pivot u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Model state of the block.
   logic [2:0]  arc_row [N_ARCS];
   logic [2:0]  arc_col [N_ARCS];
   int          arc_total;
   logic [30:0] cell_amt [64];
   int          rows_used;
   int          cols_used;

   item_t    pending_items[$];
   outcome_t awaited_outcomes[$];
   int       failures = 0;
   int       rsp_seen = 0;
   logic     req_taken = 1'b0;
   int       idle_cycles = 0;

   function automatic int clamp_size(input logic [3:0] v, input int hi);
      if (v == 4'd0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Shifts theta around the stepping-stone cycle of the entering cell.
   function automatic outcome_t pivot_cycle(input int row, input int col);
      outcome_t o;
      logic [15:0] seen;
      int parent [16];
      int fifo [16];
      int nodes [17];
      int ci [17];
      int cj [17];
      int head, tail, u, v, a, c, dst, len, cur;
      logic [30:0] theta;
      logic have_minus;
      o = '0;
      seen = '0;
      head = 0;
      tail = 0;
      dst = rows_used + col;
      fifo[tail++] = row;
      parent[row] = row;
      seen[row] = 1'b1;
      while (head < tail && !seen[dst]) begin
         u = fifo[head++];
         for (int k = 0; k < arc_total; k++) begin
            a = arc_row[k];
            if (a >= rows_used || arc_col[k] >= cols_used) continue;
            c = rows_used + arc_col[k];
            if (u == a) v = c;
            else if (u == c) v = a;
            else continue;
            if (!seen[v] && tail < N_NODES) begin
               seen[v] = 1'b1;
               parent[v] = u;
               fifo[tail++] = v;
            end
         end
      end
      if (!seen[dst]) begin
         o.status = STAT_NOPATH;
         return o;
      end
      len = 0;
      cur = dst;
      while (len < N_SUP + N_CLI) begin
         nodes[len++] = cur;
         if (cur == row) break;
         cur = parent[cur] % N_NODES;
      end
      ci[0] = row;
      cj[0] = col;
      for (int e = 0; e + 1 < len; e++) begin
         u = nodes[len-1-e];
         v = nodes[len-2-e];
         if (u < rows_used) begin
            ci[e+1] = u;
            cj[e+1] = v - rows_used;
         end else begin
            ci[e+1] = v;
            cj[e+1] = u - rows_used;
         end
      end
      theta = '0;
      have_minus = 1'b0;
      for (int e = 1; e < len; e += 2) begin
         if (!have_minus || cell_amt[ci[e]*N_CLI+cj[e]] < theta)
            theta = cell_amt[ci[e]*N_CLI+cj[e]];
         have_minus = 1'b1;
      end
      o.status = STAT_NOLEAV;
      if (!have_minus) return o;
      for (int e = 0; e < len; e++) begin
         a = ci[e]*N_CLI + cj[e];
         if (e % 2 == 0)
            cell_amt[a] = (cell_amt[a] > AMT_MAX - theta) ? AMT_MAX : cell_amt[a] + theta;
         else
            cell_amt[a] = (cell_amt[a] < theta) ? '0 : cell_amt[a] - theta;
      end
      o.theta = theta;
      for (int e = 1; e < len; e += 2) begin
         if (cell_amt[ci[e]*N_CLI+cj[e]] == '0) begin
            o.status = STAT_OK;
            o.leave_row = ci[e][2:0];
            o.leave_col = cj[e][2:0];
            break;
         end
      end
      return o;
   endfunction

   function automatic outcome_t predict_outcome(input item_t it);
      outcome_t o;
      logic bad;
      o = '0;
      bad = it.row >= rows_used || it.col >= cols_used;
      case (it.kind)
         KIND_CLEAR: arc_total = 0;
         KIND_ADD: begin
            if (bad || arc_total >= N_ARCS) begin
               o.status = STAT_RANGE;
            end else begin
               arc_row[arc_total] = it.row;
               arc_col[arc_total] = it.col;
               arc_total++;
            end
         end
         KIND_WRITE: begin
            if (bad) o.status = STAT_RANGE;
            else cell_amt[it.row*N_CLI+it.col] = it.value;
         end
         KIND_READ: begin
            if (bad) o.status = STAT_RANGE;
            else o.read_value = cell_amt[it.row*N_CLI+it.col];
         end
         KIND_PIVOT: begin
            if (bad || rows_used + cols_used > N_NODES) o.status = STAT_RANGE;
            else o = pivot_cycle(it.row, it.col);
         end
         default: ;
      endcase
      return o;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      logic     v;
      item_t    it;
      v = req_tvalid;
      it = req_tdata;
      if (!reset && (!req_tvalid || req_taken)) begin
         v = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            v = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
            end
         end
      end
      req_tvalid <= v;
      req_tdata <= it;
   end

   // Receiver: a new stall pattern is drawn each time rx_phase wraps, plus one long hold.
   int rx_mode = 0;
   int rx_phase = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   always @(negedge clock) begin
      logic r;
      r = 1'b0;
      if (!reset) begin
         if (rx_phase == 0) rx_mode = $urandom_range(0, 2);
         rx_phase = (rx_phase + 1) % 64;
         if (hold_left > 0) begin
            hold_left--;
         end else if (!hold_done && rsp_seen >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end else begin
            case (rx_mode)
               0: r = 1'b1;
               1: r = $urandom_range(0, 1);
               default: r = $urandom_range(0, 3) == 0;
            endcase
         end
      end
      rsp_tready <= r;
   end

   // Monitor: predicts at input acceptance and checks at result acceptance.
   always @(posedge clock) begin
      outcome_t got, want;
      logic fire_in, fire_out;
      fire_in = !reset && req_tvalid && req_tready;
      fire_out = !reset && rsp_tvalid && rsp_tready;
      req_taken <= fire_in;
      if (fire_in) awaited_outcomes.push_back(predict_outcome(req_tdata));
      if (fire_out) begin
         got = rsp_tdata[69:0];
         rsp_seen <= rsp_seen + 1;
         if (awaited_outcomes.size() == 0) begin
            $error("result transaction with nothing expected: %h", rsp_tdata);
            failures++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, got.status);
               failures++;
            end
            if (got.theta !== want.theta) begin
               $error("theta: expected %0d, actual %0d", want.theta, got.theta);
               failures++;
            end
            if (got.leave_row !== want.leave_row) begin
               $error("leave_row: expected %0d, actual %0d", want.leave_row, got.leave_row);
               failures++;
            end
            if (got.leave_col !== want.leave_col) begin
               $error("leave_col: expected %0d, actual %0d", want.leave_col, got.leave_col);
               failures++;
            end
            if (got.read_value !== want.read_value) begin
               $error("read_value: expected %0d, actual %0d",
                      want.read_value, got.read_value);
               failures++;
            end
         end
      end
      if (reset || fire_in || fire_out) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("transport_stepping_stone_pivot regression: fail");
         $finish;
      end
   end

   task automatic push_item(input logic [2:0] kind, input int row, input int col,
                            input logic [30:0] value);
      item_t it;
      it.kind = kind;
      it.row = row;
      it.col = col;
      it.value = value;
      pending_items.push_back(it);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || awaited_outcomes.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NSUP) rows_used = clamp_size(value, N_SUP);
      else cols_used = clamp_size(value, N_CLI);
   endtask

   function automatic logic [30:0] random_amount();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return $urandom_range(1, 20);
         2: return AMT_MAX - $urandom_range(0, 3);
         default: return $urandom() & AMT_MAX;
      endcase
   endfunction

   // A fresh spanning tree with random amounts, then pivots, reads and optional writes on it.
   task automatic tree_sequence(inout int count);
      logic [15:0] joined;
      int node, peer, r, c, total;
      total = rows_used + cols_used;
      joined = 16'h1;
      push_item(KIND_CLEAR, 0, 0, $urandom() & AMT_MAX);
      count++;
      while (joined != (16'hFFFF >> (16 - total))) begin
         node = $urandom_range(0, total - 1);
         peer = $urandom_range(0, total - 1);
         if (joined[node] || !joined[peer] || (node < rows_used) == (peer < rows_used))
            continue;
         joined[node] = 1'b1;
         r = node < rows_used ? node : peer;
         c = (node < rows_used ? peer : node) - rows_used;
         push_item(KIND_ADD, r, c, $urandom() & AMT_MAX);
         push_item(KIND_WRITE, r, c, random_amount());
         count += 2;
      end
      repeat ($urandom_range(2, 6)) begin
         r = $urandom_range(0, rows_used - 1);
         c = $urandom_range(0, cols_used - 1);
         if ($urandom_range(0, 1)) begin
            push_item(KIND_WRITE, r, c, random_amount());
            count++;
         end
         push_item(KIND_PIVOT, r, c, $urandom() & AMT_MAX);
         push_item(KIND_READ, $urandom_range(0, rows_used - 1),
                   $urandom_range(0, cols_used - 1), $urandom() & AMT_MAX);
         count += 2;
      end
   endtask

   initial begin
      int count, phase_goal;
      arc_total = 0;
      rows_used = 1;
      cols_used = 1;
      foreach (cell_amt[i]) cell_amt[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed start at the reset sizes of one row and one column.
      count = 0;
      push_item(KIND_READ, 0, 0, '0);
      push_item(KIND_PIVOT, 0, 0, '0);
      push_item(KIND_WRITE, 0, 0, AMT_MAX);
      push_item(KIND_READ, 0, 0, '0);
      push_item(KIND_ADD, 0, 0, '0);
      push_item(KIND_PIVOT, 0, 0, '0);
      push_item(KIND_READ, 0, 0, '0);
      push_item(KIND_WRITE, 1, 0, AMT_MAX);
      push_item(KIND_READ, 0, 7, '0);
      push_item(KIND_ADD, 7, 0, '0);
      push_item(KIND_PIVOT, 0, 1, '0);
      push_item(KIND_UNUSED_MIN, 7, 7, AMT_MAX);
      push_item(KIND_UNUSED_MAX, 0, 0, '0);
      push_item(KIND_CLEAR, 0, 0, '0);
      count = 14;
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         if (p < 8) begin
            write_csr(CSR_NSUP, sup_cfg[p]);
            write_csr(CSR_NCLI, cli_cfg[p]);
         end else begin
            write_csr(CSR_NSUP, $urandom_range(0, 15));
            write_csr(CSR_NCLI, $urandom_range(0, 15));
         end
         phase_goal = count + ITEM_TARGET / 10;
         while (count < phase_goal) begin
            if ($urandom_range(0, 9) < 7) begin
               tree_sequence(count);
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  push_item($urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 7), $urandom() & AMT_MAX);
                  count++;
               end
            end
         end
         wait_idle();
      end

      repeat (400) @(posedge clock);
      if (failures == 0) begin
         $display("transport_stepping_stone_pivot regression: pass");
      end else begin
         $display("transport_stepping_stone_pivot regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
